[hw/rtl/quoted_printable_decoder_macros.svh]
// Assertion macros for the quoted-printable decoder.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef QUOTED_PRINTABLE_DECODER_MACROS_SVH
`define QUOTED_PRINTABLE_DECODER_MACROS_SVH

// Same-cycle implication, inactive while reset is held.
`define QPD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, inactive while reset is held.
`define QPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/qpd_pkg.sv]
// Shared types, character codes and helpers for the quoted-printable decoder.
// No dependencies.
`timescale 1ns / 1ps

package qpd_pkg;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    localparam logic [1:0] PH_NONE      = 2'd0;
    localparam logic [1:0] PH_AFTER_EQ  = 2'd1;
    localparam logic [1:0] PH_HAVE_HIGH = 2'd2;
    localparam logic [1:0] PH_HIGH_EQ   = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FLUSH,
        S_TAIL
    } t_state;

    typedef enum logic [2:0] {
        SEL_NL,
        SEL_IN,
        SEL_HELD,
        SEL_WS,
        SEL_ESC
    } t_sel;

    typedef struct packed {
        logic emit;
        t_sel sel;
        logic run_last;
        logic capture;
        logic ws_push;
        logic line_end;
        logic line_open_set;
        logic esc_start;
        logic esc_first;
        logic esc_clear;
        logic idx_clr;
        logic idx_inc;
        logic cnt_clr;
    } t_cmd;

    typedef struct packed {
        logic       slot_free;
        logic       is_end;
        logic       is_lf;
        logic       is_cr;
        logic       is_ws;
        logic       is_eq;
        logic       is_print;
        logic [1:0] phase;
        logic       soft_brk;
        logic       count_zero;
        logic       idx_last;
        logic       held_print;
        logic       last_nl;
        logic       line_open;
    } t_status;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
            v = 4'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46)
            v = 4'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66)
            v = 4'(c - 8'h57);
        return v;
    endfunction

    function automatic logic is_printable(input logic [7:0] c);
        return (c >= CH_SPACE) && (c <= CH_TILDE);
    endfunction

endpackage

[hw/rtl/qpd_ctrl.sv]
// Sequencer of the quoted-printable decoder: decides per accepted byte and
// steps through held whitespace. Depends on qpd_pkg.
`timescale 1ns / 1ps

module qpd_ctrl
    import qpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.sel  = SEL_NL;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_status.slot_free;
                if (i_in_valid && i_status.slot_free) begin
                    o_cmd.capture = 1'b1;
                    if (i_status.is_end) begin
                        o_cmd.line_end = 1'b1;
                        if ((i_status.line_open && !i_status.soft_brk) || !i_status.last_nl) begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.sel      = SEL_NL;
                            o_cmd.run_last = 1'b1;
                        end
                    end else if (i_status.is_lf) begin
                        o_cmd.line_end = 1'b1;
                        if (!i_status.soft_brk) begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.sel      = SEL_NL;
                            o_cmd.run_last = 1'b1;
                        end
                    end else begin
                        o_cmd.line_open_set = 1'b1;
                        if (i_status.is_cr) begin
                            // carriage return is ignored
                        end else if (i_status.is_ws) begin
                            o_cmd.ws_push = 1'b1;
                        end else if (i_status.phase == PH_NONE || !i_status.count_zero) begin
                            // ordinary byte; a pending escape is cancelled
                            o_cmd.esc_start = i_status.is_eq;
                            o_cmd.esc_clear = !i_status.is_eq;
                            if (!i_status.count_zero) begin
                                o_cmd.idx_clr = 1'b1;
                                n_state       = S_FLUSH;
                            end else if (i_status.is_print && !i_status.is_eq) begin
                                o_cmd.emit     = 1'b1;
                                o_cmd.sel      = SEL_IN;
                                o_cmd.run_last = 1'b1;
                            end
                        end else if (i_status.phase == PH_AFTER_EQ) begin
                            o_cmd.esc_first = 1'b1;
                        end else begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.sel       = SEL_ESC;
                            o_cmd.run_last  = 1'b1;
                            o_cmd.esc_clear = 1'b1;
                        end
                    end
                end
            end
            S_FLUSH: begin
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_WS;
                    if (i_status.idx_last) begin
                        o_cmd.cnt_clr  = 1'b1;
                        o_cmd.run_last = !i_status.held_print;
                        n_state        = i_status.held_print ? S_TAIL : S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_TAIL: begin
                if (i_status.slot_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.sel      = SEL_HELD;
                    o_cmd.run_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/qpd_datapath.sv]
// Datapath of the quoted-printable decoder: escape and line state, held
// whitespace store, result register. Depends on qpd_pkg.
`timescale 1ns / 1ps

module qpd_datapath
    import qpd_pkg::*;
#(
    parameter int WS_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_end,
    input  logic       i_out_ready,
    input  t_cmd       i_cmd,
    output t_status    o_status,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_ws_overflow
);

    localparam int CNT_W = $clog2(WS_DEPTH + 1);
    localparam int IDX_W = $clog2(WS_DEPTH);

    logic             r_kind [WS_DEPTH];
    logic             r_rdata;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [1:0]       r_phase;
    logic [3:0]       r_high;
    logic             r_line_open;
    logic             r_last_nl;
    logic             r_overflow;
    logic [7:0]       r_byte;
    logic             r_o_valid;
    logic [7:0]       r_o_byte;
    logic             r_o_last;
    logic             r_o_ovf;
    logic [7:0]       w_emit_byte;
    logic             w_full;

    assign w_full = (r_count >= CNT_W'(WS_DEPTH));

    always_comb begin
        case (i_cmd.sel)
            SEL_NL:   w_emit_byte = CH_LF;
            SEL_IN:   w_emit_byte = i_in_byte;
            SEL_HELD: w_emit_byte = r_byte;
            SEL_WS:   w_emit_byte = r_rdata ? CH_TAB : CH_SPACE;
            SEL_ESC:  w_emit_byte = {r_high, hex_value(i_in_byte)};
            default:  w_emit_byte = CH_LF;
        endcase
    end

    always_comb begin
        if (i_cmd.idx_clr)
            n_idx = '0;
        else if (i_cmd.idx_inc)
            n_idx = r_idx + IDX_W'(1);
        else
            n_idx = r_idx;
    end

    // read address runs one step ahead so the data matches r_idx
    always_ff @(posedge i_clk) begin
        if (i_cmd.ws_push && !w_full)
            r_kind[r_count[IDX_W-1:0]] <= (i_in_byte == CH_TAB);
        r_rdata <= r_kind[n_idx];
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.capture)
            r_byte <= i_in_byte;
        if (i_cmd.emit) begin
            r_o_byte <= w_emit_byte;
            r_o_last <= i_cmd.run_last;
            r_o_ovf  <= r_overflow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_phase     <= PH_NONE;
            r_high      <= 4'd0;
            r_line_open <= 1'b0;
            r_last_nl   <= 1'b0;
            r_overflow  <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
                r_last_nl <= (w_emit_byte == CH_LF);
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end

            if (i_cmd.line_end || i_cmd.cnt_clr) begin
                r_count <= '0;
            end else if (i_cmd.ws_push) begin
                if (w_full)
                    r_overflow <= 1'b1;
                else
                    r_count <= r_count + CNT_W'(1);
            end

            if (i_cmd.line_end || i_cmd.esc_clear) begin
                r_phase <= PH_NONE;
                r_high  <= 4'd0;
            end else if (i_cmd.esc_start) begin
                r_phase <= PH_AFTER_EQ;
                r_high  <= 4'd0;
            end else if (i_cmd.esc_first) begin
                r_phase <= (i_in_byte == CH_EQ) ? PH_HIGH_EQ : PH_HAVE_HIGH;
                r_high  <= hex_value(i_in_byte);
            end

            if (i_cmd.line_end)
                r_line_open <= 1'b0;
            else if (i_cmd.line_open_set)
                r_line_open <= 1'b1;
        end
    end

    always_comb begin
        o_status.slot_free  = !r_o_valid || i_out_ready;
        o_status.is_end     = i_is_end;
        o_status.is_lf      = (i_in_byte == CH_LF);
        o_status.is_cr      = (i_in_byte == CH_CR);
        o_status.is_ws      = (i_in_byte == CH_SPACE) || (i_in_byte == CH_TAB);
        o_status.is_eq      = (i_in_byte == CH_EQ);
        o_status.is_print   = is_printable(i_in_byte);
        o_status.phase      = r_phase;
        o_status.soft_brk   = (r_phase == PH_AFTER_EQ) || (r_phase == PH_HIGH_EQ);
        o_status.count_zero = (r_count == '0);
        o_status.idx_last   = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
        o_status.held_print = is_printable(r_byte) && (r_byte != CH_EQ);
        o_status.last_nl    = r_last_nl;
        o_status.line_open  = r_line_open;
    end

    assign o_out_valid   = r_o_valid;
    assign o_out_byte    = r_o_byte;
    assign o_run_last    = r_o_last;
    assign o_ws_overflow = r_o_ovf;

endmodule

[hw/rtl/quoted_printable_decoder.sv]
// Quoted-printable body decoder, top level: sequencer plus datapath.
// Depends on qpd_pkg, qpd_ctrl, qpd_datapath, quoted_printable_decoder_macros.svh.
//
// Input channel (i_in_valid/o_in_ready) carries one encoded byte or an
// end-of-text marker per transfer. Output channel (o_out_valid/i_out_ready)
// carries decoded bytes; o_run_last marks the final result of an input
// transfer, o_ws_overflow is the sticky flag for dropped held whitespace.
// A result emitted directly by a transfer is registered and appears in the
// cycle after it. The decoder takes one byte per cycle while no whitespace is
// held and the output register is free. A byte that releases held spaces/tabs
// keeps the sequencer busy, one store read per result, while it emits them in
// turn and then the byte itself if that is emitted, before the next input is
// taken. A single output register holds the result; new input is taken while
// it is being drained in the same cycle. When the receiver stalls, the result
// is held and input is refused until the register is free. Reset
// (synchronous, active low) clears the sequencer and line, escape, count,
// overflow and output-valid state; the whitespace store needs no clearing.
`timescale 1ns / 1ps
`include "quoted_printable_decoder_macros.svh"

module quoted_printable_decoder
    import qpd_pkg::*;
#(
    parameter int WS_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_end,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_ws_overflow
);

    t_cmd    w_cmd;
    t_status w_status;

    qpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    qpd_datapath #(
        .WS_DEPTH (WS_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_byte     (i_in_byte),
        .i_is_end      (i_is_end),
        .i_out_ready   (i_out_ready),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_ws_overflow (o_ws_overflow)
    );

    `QPD_ASSERT_IMPLY(a_emit_slot_free, w_cmd.emit, w_status.slot_free, "result overwritten")
    `QPD_ASSERT_IMPLY(a_push_no_emit, w_cmd.ws_push, !w_cmd.emit, "whitespace held and emitted")
    `QPD_ASSERT_NEXT(a_ovf_sticky, o_out_valid && i_out_ready && o_ws_overflow, !o_out_valid || o_ws_overflow, "overflow flag cleared")

endmodule

[tb/quoted_printable_decoder_tb.sv]
// Self-checking testbench for quoted_printable_decoder: directed table, then random QP text.
// Depends on qpd_pkg and the quoted_printable_decoder RTL.
`timescale 1ns / 1ps

module quoted_printable_decoder_tb;
    import qpd_pkg::*;

    localparam int WS_DEPTH = 32;
    localparam int N_DIRECTED = 38;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       ovf;
    } t_qp_out;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
    } t_qp_item;

    // typed_n < 0: results come from the decode model; 1: one result of typed_ch; 0: no result
    typedef struct {
        logic [7:0] ch;
        logic       fin;
        int         reps;
        int         typed_n;
        logic [7:0] typed_ch;
    } t_qp_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_in_byte;
    logic       i_is_end;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_byte;
    logic       o_run_last;
    logic       o_ws_overflow;

    quoted_printable_decoder #(
        .WS_DEPTH(WS_DEPTH)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_byte(i_in_byte),
        .i_is_end(i_is_end),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_byte(o_out_byte),
        .o_run_last(o_run_last),
        .o_ws_overflow(o_ws_overflow)
    );

    // decoder model state
    logic       ws_kind_mem [0:63];
    int         ws_held;
    logic [1:0] esc_phase;
    logic [3:0] esc_hi;
    logic       nl_last;
    logic       ovf_sticky;
    logic       line_busy;

    t_qp_out  step_q[$];
    t_qp_out  decoded_q[$];
    t_qp_item burst_q[$];

    int         err_cnt = 0;
    int         tx_idle_pct = 30;
    int         rx_idle_pct = 79;
    int         rx_hold_left = 0;
    int         row_typed_n = -1;
    logic [7:0] row_typed_ch = 8'h00;

    t_qp_row dir_rows [0:N_DIRECTED-1] = '{
        '{8'h00,    1'b1, 1, 1, CH_LF},     // empty text still gives one newline
        '{8'h41,    1'b0, 1, 1, 8'h41},
        '{8'h00,    1'b0, 1, 0, 8'h00},
        '{8'hFF,    1'b0, 1, 0, 8'h00},
        '{8'h7F,    1'b0, 1, 0, 8'h00},
        '{CH_TILDE, 1'b0, 1, 1, CH_TILDE},
        '{CH_SPACE, 1'b0, 1, 0, 8'h00},
        '{CH_TAB,   1'b0, 1, 0, 8'h00},
        '{CH_CR,    1'b0, 1, 0, 8'h00},     // CR neither kept nor held
        '{8'h3C,    1'b0, 1, -1, 8'h00},
        '{CH_EQ,    1'b0, 1, 0, 8'h00},
        '{8'h61,    1'b0, 1, 0, 8'h00},
        '{8'h46,    1'b0, 1, 1, 8'hAF},     // mixed case hex
        '{CH_EQ,    1'b0, 1, 0, 8'h00},
        '{8'h30,    1'b0, 1, 0, 8'h00},
        '{8'h67,    1'b0, 1, 1, 8'h00},     // non-hex digit reads as zero
        '{CH_EQ,    1'b0, 1, 0, 8'h00},
        '{CH_LF,    1'b0, 1, 0, 8'h00},     // soft break
        '{CH_EQ,    1'b0, 1, 0, 8'h00},
        '{8'h42,    1'b0, 1, 0, 8'h00},
        '{CH_LF,    1'b0, 1, 1, CH_LF},     // escape cut short after first digit
        '{CH_EQ,    1'b0, 1, 0, 8'h00},
        '{CH_SPACE, 1'b0, 2, 0, 8'h00},
        '{8'h7A,    1'b0, 1, -1, 8'h00},    // cancels the escape, flushes spaces
        '{CH_EQ,    1'b0, 1, 0, 8'h00},
        '{CH_EQ,    1'b0, 1, 0, 8'h00},
        '{CH_LF,    1'b0, 1, 0, 8'h00},     // "==" at line end is soft too
        '{CH_SPACE, 1'b0, 1, 0, 8'h00},
        '{CH_LF,    1'b0, 1, 1, CH_LF},     // trailing space discarded
        '{8'h71,    1'b0, 1, -1, 8'h00},
        '{8'h00,    1'b1, 1, -1, 8'h00},    // end closes the open line
        '{8'h78,    1'b0, 1, -1, 8'h00},
        '{CH_EQ,    1'b0, 1, 0, 8'h00},
        '{8'h00,    1'b1, 1, -1, 8'h00},    // end during escape
        '{CH_SPACE, 1'b0, WS_DEPTH + 1, 0, 8'h00},
        '{8'h21,    1'b0, 1, -1, 8'h00},
        '{CH_LF,    1'b0, 1, -1, 8'h00},
        '{8'h55,    1'b1, 1, 0, 8'h00}      // end right after a newline: nothing
    };

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("quoted_printable_decoder_tb NOT OK");
        $finish;
    end

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return c[3:0];
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            return c[3:0] + 4'd9;
        return 4'd0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input logic lower);
        if (v < 4'd10)
            return 8'h30 + 8'(v);
        return (lower ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
    endfunction

    task automatic qp_emit(input logic [7:0] b);
        t_qp_out r;
        r.ch = b;
        r.last = 1'b0;
        r.ovf = ovf_sticky;
        step_q.push_back(r);
        nl_last = (b == CH_LF);
    endtask

    task automatic qp_line_end();
        ws_held = 0;
        if (esc_phase != PH_AFTER_EQ && esc_phase != PH_HIGH_EQ)
            qp_emit(CH_LF);
        esc_phase = PH_NONE;
        esc_hi = 4'd0;
        line_busy = 1'b0;
    endtask

    task automatic qp_plain(input logic [7:0] b);
        for (int i = 0; i < ws_held; i++)
            qp_emit(ws_kind_mem[i] ? CH_TAB : CH_SPACE);
        ws_held = 0;
        if (b == CH_EQ)
            esc_phase = PH_AFTER_EQ;
        else if (b >= CH_SPACE && b <= CH_TILDE)
            qp_emit(b);
    endtask

    // Leaves the results of one input transfer in step_q.
    task automatic qp_decode_step(input logic [7:0] b, input logic fin);
        step_q.delete();
        if (fin) begin
            if (line_busy)
                qp_line_end();
            if (!nl_last)
                qp_emit(CH_LF);
            ws_held = 0;
            esc_phase = PH_NONE;
            esc_hi = 4'd0;
            line_busy = 1'b0;
        end else if (b == CH_LF) begin
            qp_line_end();
        end else begin
            line_busy = 1'b1;
            if (b == CH_SPACE || b == CH_TAB) begin
                if (ws_held >= WS_DEPTH) begin
                    ovf_sticky = 1'b1;
                end else begin
                    ws_kind_mem[ws_held] = (b == CH_TAB);
                    ws_held++;
                end
            end else if (b != CH_CR) begin
                if (esc_phase == PH_NONE) begin
                    qp_plain(b);
                end else if (ws_held != 0) begin
                    esc_phase = PH_NONE;
                    esc_hi = 4'd0;
                    qp_plain(b);
                end else if (esc_phase == PH_AFTER_EQ) begin
                    esc_hi = nibble_of(b);
                    esc_phase = (b == CH_EQ) ? PH_HIGH_EQ : PH_HAVE_HIGH;
                end else begin
                    qp_emit({esc_hi, nibble_of(b)});
                    esc_phase = PH_NONE;
                    esc_hi = 4'd0;
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_cnt < 40)
            $display("%0t ns: %s: got 0x%02h, want 0x%02h", $time, what, got, want);
        err_cnt++;
    endtask

    // Output check first, then prediction: a result never leaves in the cycle of its input.
    always @(posedge i_clk) begin : scoreboard
        t_qp_out want;
        t_qp_out r;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("unexpected result", o_out_byte, 0);
                end else begin
                    want = decoded_q.pop_front();
                    if (o_out_byte !== want.ch)
                        report_mismatch("out_byte", o_out_byte, want.ch);
                    if (o_run_last !== want.last)
                        report_mismatch("run_last", o_run_last, want.last);
                    if (o_ws_overflow !== want.ovf)
                        report_mismatch("ws_overflow", o_ws_overflow, want.ovf);
                end
            end
            if (i_in_valid && o_in_ready) begin
                qp_decode_step(i_in_byte, i_is_end);
                if (row_typed_n < 0) begin
                    foreach (step_q[i]) begin
                        r = step_q[i];
                        r.last = (i == step_q.size() - 1);
                        decoded_q.push_back(r);
                    end
                end else if (row_typed_n == 1) begin
                    r.ch = row_typed_ch;
                    r.last = 1'b1;
                    r.ovf = 1'b0;
                    decoded_q.push_back(r);
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when rx_hold_left is loaded.
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic [7:0] b, input logic fin, input int tn,
                             input logic [7:0] tc);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_byte <= b;
        i_is_end <= fin;
        row_typed_n = tn;
        row_typed_ch = tc;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic add_item(input logic [7:0] b, input logic fin);
        t_qp_item it;
        it.ch = b;
        it.fin = fin;
        burst_q.push_back(it);
    endtask

    // One random fragment of encoded text, mostly well-formed.
    task automatic build_burst();
        int k;
        int n;
        k = $urandom_range(99);
        if (k < 38) begin
            add_item(8'($urandom_range(33, 126)), 1'b0);
        end else if (k < 55) begin
            add_item(CH_EQ, 1'b0);
            add_item(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))), 1'b0);
            if ($urandom_range(9) == 0)
                add_item(8'($urandom_range(255)), 1'b0);
            else
                add_item(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))), 1'b0);
        end else if (k < 66) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 4);
            repeat (n) add_item($urandom_range(1) ? CH_TAB : CH_SPACE, 1'b0);
        end else if (k < 76) begin
            if ($urandom_range(1))
                add_item(CH_CR, 1'b0);
            add_item(CH_LF, 1'b0);
        end else if (k < 82) begin
            add_item(CH_EQ, 1'b0);
            repeat ($urandom_range(2)) add_item(CH_SPACE, 1'b0);
            add_item(CH_LF, 1'b0);
        end else if (k < 88) begin
            add_item(CH_EQ, 1'b0);
            if ($urandom_range(1))
                add_item(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))), 1'b0);
            repeat ($urandom_range(1, 3)) add_item($urandom_range(1) ? CH_TAB : CH_SPACE, 1'b0);
            add_item(8'($urandom_range(33, 126)), 1'b0);
        end else if (k < 96) begin
            add_item(8'($urandom_range(255)), 1'b0);
        end else begin
            add_item(8'($urandom_range(255)), 1'b1);
        end
    endtask

    task automatic run_random(input int n_items);
        int sent;
        t_qp_item it;
        sent = 0;
        while (sent < n_items) begin
            build_burst();
            while (burst_q.size() != 0) begin
                it = burst_q.pop_front();
                send_item(it.ch, it.fin, -1, 8'h00);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_byte = 8'h00;
        i_is_end = 1'b0;
        i_out_ready = 1'b0;
        ws_held = 0;
        esc_phase = PH_NONE;
        esc_hi = 4'd0;
        nl_last = 1'b0;
        ovf_sticky = 1'b0;
        line_busy = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i])
            repeat (dir_rows[i].reps)
                send_item(dir_rows[i].ch, dir_rows[i].fin, dir_rows[i].typed_n,
                          dir_rows[i].typed_ch);
        run_random(50);
        drain_results();

        tx_idle_pct = 79;
        rx_idle_pct = 30;
        run_random(25);
        // sender waits for every result before carrying on
        drain_results();
        run_random(25);
        drain_results();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // long receiver hold-off while transfers keep being offered
        rx_hold_left = 300;
        run_random(50);
        drain_results();

        repeat (50) @(posedge i_clk);
        if (err_cnt == 0)
            $display("quoted_printable_decoder_tb OK");
        else
            $display("quoted_printable_decoder_tb NOT OK");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/qpd_pkg.sv
hw/rtl/qpd_ctrl.sv
hw/rtl/qpd_datapath.sv
hw/rtl/quoted_printable_decoder.sv
tb/quoted_printable_decoder_tb.sv
